FILE: rtl/core/ffca_pkg.sv
package ffca_pkg;

  localparam int REQ_W = 17;
  localparam int OFF_W = 16;
  localparam int ST_W  = 2;
  localparam int SW    = 18;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_UNINIT = 2'd1,
    ST_OOM    = 2'd2,
    ST_BADARG = 2'd3
  } status_t;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CFG_Q,
    S_CFG_T,
    S_SCAN,
    S_SHUP,
    S_WR0,
    S_WR1,
    S_NXT_RD,
    S_NXT_CHK,
    S_SHDN,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/ffca_mem.sv
module ffca_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ffca_pkg::ent_t  wdata,
  input  logic [AW-1:0]   raddr,
  output ffca_pkg::ent_t  rdata
);
  import ffca_pkg::*;

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/first_fit_chunk_allocator.sv
// First-fit allocator over an address-ordered chunk table held in one
// synchronous RAM. Writing arena_request_bytes (nonzero, up to
// MAX_ARENA_BYTES) rounds it up to whole pages and restarts the arena as one
// free chunk; zero makes the arena uninitialized. An allocate or free walks
// the table one entry per cycle through the RAM read port, and a split or
// merge then shifts the tail of the table one entry per cycle through the
// same port. The next transaction is accepted only after the result is
// loaded; one transaction is in flight at a time, and the result sits in an
// output register.
module first_fit_chunk_allocator #(
  parameter int MAX_ARENA_BYTES = 65536,
  parameter int PAGE_BYTES      = 4096,
  parameter int HEADER_BYTES    = 32,
  parameter int MAX_CHUNKS      = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [ffca_pkg::REQ_W-1:0]  request_size,
  input  logic [ffca_pkg::OFF_W-1:0]  payload_offset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffca_pkg::OFF_W-1:0]  granted_offset,
  output logic [ffca_pkg::ST_W-1:0]   status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffca_pkg::REQ_W-1:0]  arena_request_bytes
);
  import ffca_pkg::*;

  localparam int IW  = $clog2(MAX_CHUNKS);
  localparam int CW  = $clog2(MAX_CHUNKS + 1);
  localparam int PSH = 36;
  localparam longint RECIP = ((64'd1 << PSH) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int RW  = PSH - $clog2(PAGE_BYTES) + 1;
  localparam logic [SW-1:0] HDR  = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] PGM1 = SW'(PAGE_BYTES - 1);
  localparam logic [SW-1:0] PG   = SW'(PAGE_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);

  state_t state, state_next;

  logic              op_r;
  logic [SW-1:0]     req_r, off_r;
  logic [CW-1:0]     cnt;
  logic [SW-1:0]     total;
  logic [SW-1:0]     cfg_v;
  logic [SW-1:0]     q_r;
  logic [CW-1:0]     ai, ci, hit_idx;
  logic              chk_vld, split_r, pend;
  ent_t              hit_ent, prev_ent;
  logic [CW:0]       j;
  logic [IW-1:0]     wa;
  logic [1:0]        ksh;
  logic [OFF_W-1:0]  res_off;
  status_t           res_st;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  ent_t              wdata, rdata;

  ffca_mem #(.DEPTH(MAX_CHUNKS), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic              in_hs, cfg_hs, cfg_ok;
  logic [SW-1:0]     cfg_ext;
  logic [SW+RW-1:0]  prod;
  logic [SW-1:0]     tot_calc;
  logic              scan_issue, hit, miss_end, alloc_split;
  logic              nxt_m, prv_m;
  logic [SW-1:0]     msize;
  ent_t              tgt_ent;
  logic [CW-1:0]     tgt_idx;
  logic [1:0]        kk;
  logic [CW-1:0]     hit_p1;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign in_hs     = in_valid && in_ready;
  assign cfg_hs    = cfg_valid && cfg_ready;
  assign cfg_ext   = SW'(arena_request_bytes);
  assign cfg_ok    = 32'(arena_request_bytes) <= 32'(MAX_ARENA_BYTES);

  assign prod     = (SW+RW)'(cfg_v + PGM1) * (SW+RW)'(RECIP[RW-1:0]);
  assign tot_calc = SW'(q_r * PG);

  assign scan_issue = (ai < cnt);
  assign hit = chk_vld && (op_r ? ((rdata.start + HDR) == off_r)
                                : (rdata.free && (rdata.size >= req_r)));
  assign miss_end = !hit && !scan_issue;
  assign alloc_split = (rdata.size > (req_r + HDR)) && (cnt < MAXC);

  assign hit_p1  = hit_idx + CW'(1);
  assign nxt_m   = (hit_p1 < cnt) && rdata.free;
  assign prv_m   = (hit_idx != '0) && prev_ent.free;
  assign msize   = hit_ent.size + (nxt_m ? (HDR + rdata.size) : '0);
  assign kk      = {1'b0, nxt_m} + {1'b0, prv_m};
  assign tgt_idx = prv_m ? (hit_idx - CW'(1)) : hit_idx;
  always_comb begin
    tgt_ent.free  = 1'b1;
    tgt_ent.start = prv_m ? prev_ent.start : hit_ent.start;
    tgt_ent.size  = prv_m ? (prev_ent.size + HDR + msize) : msize;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_hs) begin
          if (total == '0 || (!operation && SW'(request_size) >= total) ||
              (operation && payload_offset == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end else if (cfg_hs && cfg_ok && arena_request_bytes != '0) begin
          state_next = S_CFG_Q;
        end
      end
      S_CFG_Q: state_next = S_CFG_T;
      S_CFG_T: state_next = S_IDLE;
      S_SCAN: begin
        if (hit) begin
          if (op_r) state_next = S_NXT_RD;
          else if (alloc_split) state_next = S_SHUP;
          else state_next = S_WR0;
        end else if (miss_end) begin
          state_next = S_DONE;
        end
      end
      S_SHUP: begin
        if (!(j > (CW+1)'(hit_idx))) state_next = S_WR0;
      end
      S_WR0: state_next = split_r ? S_WR1 : S_DONE;
      S_WR1: state_next = S_DONE;
      S_NXT_RD: state_next = S_NXT_CHK;
      S_NXT_CHK: state_next = (kk == 2'd0) ? S_DONE : S_SHDN;
      S_SHDN: begin
        if (!(j < (CW+1)'(cnt))) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_CFG_T: begin
        we = 1'b1;
        wdata.start = '0;
        wdata.size  = tot_calc - HDR;
        wdata.free  = 1'b1;
      end
      S_SCAN: raddr = ai[IW-1:0];
      S_SHUP, S_SHDN: begin
        raddr = j[IW-1:0];
        if (pend) begin
          we    = 1'b1;
          waddr = wa;
          wdata = rdata;
        end
      end
      S_WR0: begin
        we = 1'b1;
        waddr = hit_idx[IW-1:0];
        wdata.start = hit_ent.start;
        wdata.size  = split_r ? req_r : hit_ent.size;
        wdata.free  = 1'b0;
      end
      S_WR1: begin
        we = 1'b1;
        waddr = hit_p1[IW-1:0];
        wdata.start = hit_ent.start + HDR + req_r;
        wdata.size  = hit_ent.size - HDR - req_r;
        wdata.free  = 1'b1;
      end
      S_NXT_RD: raddr = hit_p1[IW-1:0];
      S_NXT_CHK: begin
        we    = 1'b1;
        waddr = tgt_idx[IW-1:0];
        wdata = tgt_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_hs) begin
            op_r    <= operation;
            req_r   <= SW'(request_size);
            off_r   <= SW'(payload_offset);
            res_off <= '0;
            ai      <= '0;
            chk_vld <= 1'b0;
            if (total == '0) res_st <= ST_UNINIT;
            else if (!operation && SW'(request_size) >= total) res_st <= ST_OOM;
            else if (operation && payload_offset == '0) res_st <= ST_BADARG;
            else res_st <= ST_OK;
          end else if (cfg_hs && cfg_ok) begin
            if (arena_request_bytes == '0) begin
              total <= '0;
              cnt   <= '0;
            end else begin
              cfg_v <= cfg_ext;
            end
          end
        end
        S_CFG_Q: q_r <= prod[PSH +: SW];
        S_CFG_T: begin
          total <= tot_calc;
          cnt   <= CW'(1);
        end
        S_SCAN: begin
          chk_vld <= scan_issue;
          ci      <= ai;
          if (scan_issue) ai <= ai + CW'(1);
          if (chk_vld && !hit) prev_ent <= rdata;
          if (hit) begin
            hit_idx <= ci;
            hit_ent <= rdata;
            split_r <= alloc_split;
            j       <= (CW+1)'(cnt) - (CW+1)'(1);
            pend    <= 1'b0;
          end else if (miss_end) begin
            res_st <= op_r ? ST_BADARG : ST_OOM;
          end
        end
        S_SHUP: begin
          if (j > (CW+1)'(hit_idx)) begin
            pend <= 1'b1;
            wa   <= IW'(j + (CW+1)'(1));
            j    <= j - (CW+1)'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_WR0: begin
          res_off <= OFF_W'(hit_ent.start + HDR);
          res_st  <= ST_OK;
        end
        S_WR1: cnt <= cnt + CW'(1);
        S_NXT_CHK: begin
          res_st <= ST_OK;
          ksh    <= kk;
          pend   <= 1'b0;
          j      <= (CW+1)'(tgt_idx) + (CW+1)'(kk) + (CW+1)'(1);
        end
        S_SHDN: begin
          if (j < (CW+1)'(cnt)) begin
            pend <= 1'b1;
            wa   <= IW'(j - (CW+1)'(ksh));
            j    <= j + (CW+1)'(1);
          end else begin
            pend <= 1'b0;
            cnt  <= cnt - CW'(ksh);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            granted_offset <= res_off;
            status         <= res_st;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= MAXC) else $error("chunk count above table depth");

  a_idle_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((cnt == '0) == (total == '0)))
    else $error("chunk count and arena size disagree");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted_offset != '0) |-> (status == ST_OK))
    else $error("offset granted with failing status");

  a_scan_init: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (total != '0))
    else $error("table walk on uninitialized arena");
`endif

endmodule

FILE: test/first_fit_chunk_allocator_tb.sv
module first_fit_chunk_allocator_tb;
  import ffca_pkg::*;

  localparam int MAX_ARENA = 65536;
  localparam int PAGE = 4096;
  localparam int HDR = 32;
  localparam int MAXC = 64;
  localparam int WDOG_LIMIT = 20000;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic operation = 0;
  logic [REQ_W-1:0] request_size = '0;
  logic [OFF_W-1:0] payload_offset = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [OFF_W-1:0] granted_offset;
  logic [ST_W-1:0] status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [REQ_W-1:0] arena_request_bytes = '0;

  first_fit_chunk_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .request_size(request_size),
    .payload_offset(payload_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted_offset(granted_offset), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .arena_request_bytes(arena_request_bytes)
  );

  always #6 clk = ~clk;

  // allocator shadow
  int unsigned tbl_start[MAXC];
  int unsigned tbl_size[MAXC];
  bit tbl_free[MAXC];
  int unsigned tbl_count = 0;
  int unsigned arena_bytes = 0;

  typedef struct {
    logic [OFF_W-1:0] offset;
    status_t st;
  } grant_t;
  grant_t pending_grants[$];
  logic [OFF_W-1:0] live_offsets[$];

  int errors = 0;
  bit quiet_out = 0;
  bit hold_out = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  function automatic void tbl_remove(int unsigned idx);
    for (int unsigned i = idx; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_size[i] = tbl_size[i+1];
      tbl_free[i] = tbl_free[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void arena_write(int unsigned v);
    if (v > MAX_ARENA) return;
    if (v == 0) begin
      arena_bytes = 0;
      tbl_count = 0;
      return;
    end
    arena_bytes = ((v + PAGE - 1) / PAGE) * PAGE;
    tbl_start[0] = 0;
    tbl_size[0] = arena_bytes - HDR;
    tbl_free[0] = 1;
    tbl_count = 1;
  endfunction

  function automatic grant_t predict_grant(logic op, int unsigned req, int unsigned off);
    grant_t g;
    int unsigned idx;
    bit found;
    g.offset = '0;
    g.st = ST_OK;
    if (arena_bytes == 0) begin
      g.st = ST_UNINIT;
      return g;
    end
    if (op == OP_ALLOC) begin
      if (req >= arena_bytes) begin
        g.st = ST_OOM;
        return g;
      end
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (!tbl_free[i] || tbl_size[i] < req) continue;
        if (tbl_size[i] > req + HDR && tbl_count < MAXC) begin
          for (int unsigned j = tbl_count; j > i + 1; j--) begin
            tbl_start[j] = tbl_start[j-1];
            tbl_size[j] = tbl_size[j-1];
            tbl_free[j] = tbl_free[j-1];
          end
          tbl_start[i+1] = tbl_start[i] + HDR + req;
          tbl_size[i+1] = tbl_size[i] - HDR - req;
          tbl_free[i+1] = 1;
          tbl_count++;
          tbl_size[i] = req;
        end
        tbl_free[i] = 0;
        g.offset = OFF_W'(tbl_start[i] + HDR);
        return g;
      end
      g.st = ST_OOM;
      return g;
    end
    if (off == 0) begin
      g.st = ST_BADARG;
      return g;
    end
    found = 0;
    idx = 0;
    for (int unsigned i = 0; i < tbl_count; i++)
      if (tbl_start[i] + HDR == off) begin
        idx = i;
        found = 1;
        break;
      end
    if (!found) begin
      g.st = ST_BADARG;
      return g;
    end
    tbl_free[idx] = 1;
    while (idx + 1 < tbl_count && tbl_free[idx+1]) begin
      tbl_size[idx] += HDR + tbl_size[idx+1];
      tbl_remove(idx + 1);
    end
    while (idx > 0 && tbl_free[idx-1]) begin
      tbl_size[idx-1] += HDR + tbl_size[idx];
      tbl_remove(idx);
      idx--;
    end
    return g;
  endfunction

  // valid stays up after acceptance until the next transaction or an idle stretch
  task automatic send_request(logic op, int unsigned req, int unsigned off, bit gaps = 1);
    grant_t g;
    if (gaps && !quiet_out && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    request_size <= REQ_W'(req);
    payload_offset <= OFF_W'(off);
    do @(posedge clk); while (!in_ready);
    g = predict_grant(op, req, off);
    pending_grants.push_back(g);
    if (op == OP_ALLOC && g.st == ST_OK) live_offsets.push_back(g.offset);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (3 + 2 * MAXC + 10) @(posedge clk);
  endtask

  task automatic write_arena(int unsigned v);
    drain();
    cfg_valid <= 1;
    arena_request_bytes <= REQ_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    arena_write(v);
    live_offsets.delete();
  endtask

  task automatic free_random_live();
    int k;
    if (live_offsets.size() == 0) begin
      send_request(OP_FREE, 0, $urandom_range(0, 65535));
      return;
    end
    k = $urandom_range(0, live_offsets.size() - 1);
    send_request(OP_FREE, 0, live_offsets[k]);
    if ($urandom_range(0, 9) != 0) live_offsets.delete(k);
  endtask

  task automatic random_request();
    int r;
    int unsigned sz;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
         : ($urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 2048));
      send_request(OP_ALLOC, sz, $urandom_range(0, 65535));
    end else if (r < 90) begin
      free_random_live();
    end else begin
      send_request(OP_FREE, $urandom_range(0, 131071), $urandom_range(0, 65535));
    end
  endtask

  task automatic test_uninitialized();
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_FREE, 0, 32);
    send_request(OP_FREE, 131071, 16'hFFFF);
  endtask

  task automatic test_directed();
    write_arena(1);
    send_request(OP_ALLOC, 4096, 0);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 100, 0);
    send_request(OP_FREE, 0, 0);
    send_request(OP_FREE, 0, 33);
    send_request(OP_FREE, 0, 32);
    send_request(OP_FREE, 0, 32);
    send_request(OP_FREE, 0, 64);
    send_request(OP_ALLOC, 4064, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_FREE, 0, 32);
    write_arena(65537);
    send_request(OP_ALLOC, 4064, 0);
    write_arena(131071);
    write_arena(MAX_ARENA);
    send_request(OP_ALLOC, 65536, 0);
    send_request(OP_ALLOC, 65504, 0);
    send_request(OP_FREE, 0, 32);
    send_request(OP_ALLOC, 65503, 0);
    send_request(OP_ALLOC, 1, 16'hFFFF);
    send_request(OP_FREE, 0, 32);
    write_arena(0);
    send_request(OP_ALLOC, 8, 0);
  endtask

  task automatic test_table_full();
    write_arena(8192);
    for (int i = 0; i < 70; i++) send_request(OP_ALLOC, $urandom_range(0, 20), 0);
    for (int i = 0; i < 20; i++) free_random_live();
    send_request(OP_ALLOC, 60, 0);
  endtask

  task automatic test_backpressure();
    write_arena(16384);
    hold_cycles = 400;
    hold_out <= 1;
    for (int i = 0; i < 8; i++) send_request(OP_ALLOC, 40, 0, 0);
    // pause until the allocator is fully drained
    in_valid <= 0;
    while (pending_grants.size() != 0) @(posedge clk);
    for (int i = 0; i < 6; i++) free_random_live();
  endtask

  task automatic test_random();
    int unsigned sizes[6] = '{4096, 100, 20000, 65536, 40000, 12289};
    for (int phase = 0; phase < 6; phase++) begin
      write_arena(sizes[phase]);
      for (int i = 0; i < 180; i++) random_request();
    end
    quiet_out = 1;
    write_arena(3000);
    for (int i = 0; i < 150; i++) random_request();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    test_uninitialized();
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_out) begin
      out_ready <= 0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else hold_out <= 0;
    end else if (quiet_out) begin
      out_ready <= 1;
    end else if (idle_cycles > 0) begin
      out_ready <= 0;
      idle_cycles <= idle_cycles - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 0;
      idle_cycles <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $error("transaction with no expected result");
        errors++;
      end else begin
        g = pending_grants.pop_front();
        if (granted_offset !== g.offset) begin
          $error("granted_offset expected %0d actual %0d", g.offset, granted_offset);
          errors++;
        end
        if (status !== g.st) begin
          $error("status expected %0d actual %0d", g.st, status);
          errors++;
        end
      end
    end
  end

  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_out)
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
